>>> hdl/isrt_pkg.sv
// Shared widths, types and cell control for the insertion sort engine.
`timescale 1ns / 1ps

package isrt_pkg;

    localparam int DEPTH      = 64;
    localparam int DATA_WIDTH = 32;
    localparam int CNT_W      = $clog2(DEPTH + 1);

    typedef logic signed [DATA_WIDTH-1:0] t_data;
    typedef logic [CNT_W-1:0]             t_count;

    typedef struct packed {
        logic  ins;
        logic  shl;
        t_data val;
    } t_cell_ctl;

endpackage

>>> hdl/insertion_sort_engine.sv
// Top level: chain of sorting cells with load and drain control.
//
//   channel  direction  handshake                   payload
//   in       input      i_in_valid / o_in_ready     i_value, i_batch_end
//   out      output     o_out_valid / i_out_ready   o_sorted_value, o_final_result, o_overflowed
//
// Loading takes one item per cycle while no drain is pending; every cell compares against the new value at once.
// An item with batch end starts a drain of n results (n = stored count, 1..DEPTH),
// one per cycle out of cell zero; input is held off until the final result is taken.
// Synchronous active-low reset clears the count, overflow flag and drain state.
// An output stall freezes the whole chain.
`timescale 1ns / 1ps

module insertion_sort_engine import isrt_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    output logic  o_in_ready,
    input  t_data i_value,
    input  logic  i_batch_end,
    output logic  o_out_valid,
    input  logic  i_out_ready,
    output t_data o_sorted_value,
    output logic  o_final_result,
    output logic  o_overflowed
);

    t_count r_count;
    t_count n_count;
    t_count r_left;
    t_count n_left;
    logic   r_ovf;
    logic   n_ovf;
    logic   r_emit;
    logic   n_emit;

    logic      in_fire;
    logic      out_fire;
    logic      has_room;
    t_cell_ctl ctl;

    t_data cell_val [DEPTH];
    logic  cell_gt  [DEPTH];

    assign in_fire  = i_in_valid && o_in_ready;
    assign out_fire = o_out_valid && i_out_ready;
    assign has_room = r_count < t_count'(DEPTH);

    assign ctl.ins = in_fire && has_room;
    assign ctl.shl = out_fire;
    assign ctl.val = i_value;

    genvar g;
    generate
        for (g = 0; g < DEPTH; g++) begin : g_cell
            isrt_cell u_cell (
                .i_clk      (i_clk),
                .i_ctl      (ctl),
                .i_occ      (t_count'(g) < r_count),
                .i_tail     (t_count'(g) == r_count),
                .i_prev_val ((g == 0) ? t_data'(0) : cell_val[(g == 0) ? 0 : g - 1]),
                .i_prev_gt  ((g == 0) ? 1'b0 : cell_gt[(g == 0) ? 0 : g - 1]),
                .i_next_val ((g == DEPTH - 1) ? t_data'(0)
                                              : cell_val[(g == DEPTH - 1) ? g : g + 1]),
                .o_val      (cell_val[g]),
                .o_gt       (cell_gt[g])
            );
        end
    endgenerate

    always_comb begin
        n_count = r_count;
        n_left  = r_left;
        n_ovf   = r_ovf;
        n_emit  = r_emit;
        if (in_fire) begin
            if (has_room) begin
                n_count = r_count + t_count'(1);
            end else begin
                n_ovf = 1'b1;
            end
            if (i_batch_end) begin
                n_emit = 1'b1;
                n_left = has_room ? r_count + t_count'(1) : r_count;
            end
        end
        if (out_fire) begin
            n_left = r_left - t_count'(1);
            if (r_left == t_count'(1)) begin
                n_emit  = 1'b0;
                n_count = '0;
                n_ovf   = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_left  <= '0;
            r_ovf   <= 1'b0;
            r_emit  <= 1'b0;
        end else begin
            r_count <= n_count;
            r_left  <= n_left;
            r_ovf   <= n_ovf;
            r_emit  <= n_emit;
        end
    end

    assign o_in_ready     = !r_emit;
    assign o_out_valid    = r_emit;
    assign o_sorted_value = cell_val[0];
    assign o_final_result = r_left == t_count'(1);
    assign o_overflowed   = r_ovf;

endmodule

>>> hdl/isrt_cell.sv
// One sorting cell: holds one entry, compares, shifts right on insert, left on drain.
`timescale 1ns / 1ps

module isrt_cell import isrt_pkg::*; (
    input  logic      i_clk,
    input  t_cell_ctl i_ctl,
    input  logic      i_occ,
    input  logic      i_tail,
    input  t_data     i_prev_val,
    input  logic      i_prev_gt,
    input  t_data     i_next_val,
    output t_data     o_val,
    output logic      o_gt
);

    t_data r_val;
    t_data n_val;

    assign o_gt  = i_occ && (r_val > i_ctl.val);
    assign o_val = r_val;

    always_comb begin
        n_val = r_val;
        if (i_ctl.ins) begin
            if (i_prev_gt) begin
                n_val = i_prev_val;
            end else if (o_gt || i_tail) begin
                n_val = i_ctl.val;
            end
        end else if (i_ctl.shl) begin
            n_val = i_next_val;
        end
    end

    always_ff @(posedge i_clk) begin
        r_val <= n_val;
    end

endmodule

>>> hdl/isrt_chk.sv
// Port-level checker for the insertion sort engine, bound to the top level.
`timescale 1ns / 1ps

module isrt_chk import isrt_pkg::*; (
    input logic  i_clk,
    input logic  i_rst_n,
    input logic  i_in_valid,
    input logic  o_in_ready,
    input t_data i_value,
    input logic  i_batch_end,
    input logic  o_out_valid,
    input logic  i_out_ready,
    input t_data o_sorted_value,
    input logic  o_final_result,
    input logic  o_overflowed
);

    logic in_fire;
    logic out_fire;

    assign in_fire  = i_in_valid && o_in_ready;
    assign out_fire = o_out_valid && i_out_ready;

    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !o_in_ready)
        else $error("request accepted while draining");

    a_end_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire && i_batch_end |=> o_out_valid)
        else $error("batch end did not start drain");

    a_ascending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_fire && !o_final_result |=>
            o_out_valid && (o_sorted_value >= $past(o_sorted_value)))
        else $error("results out of order");

    a_final_stops: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_fire && o_final_result |=> !o_out_valid)
        else $error("result after final");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=>
            o_out_valid && $stable(o_sorted_value) && $stable(o_overflowed))
        else $error("stalled result changed");

endmodule

bind insertion_sort_engine isrt_chk u_isrt_chk (.*);

>>> test/tb.sv
// Self-checking testbench for the insertion sort engine: batches in, sorted results checked.
`timescale 1ns / 1ps

module tb;
    import isrt_pkg::*;

    localparam int    CLK_PERIOD = 12;
    localparam int    RANDOM_ITEMS = 51;
    localparam int    DRAIN_WAIT = 2 * DEPTH + 16;
    localparam t_data VMIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};
    localparam t_data VMAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};

    typedef struct {
        t_data value;
        logic  batch_end;
        logic  wait_drain;
    } t_request;

    typedef struct {
        t_data value;
        logic  last;
        logic  ovf;
    } t_result;

    logic  i_clk = 1'b0;
    logic  i_rst_n = 1'b0;
    logic  i_in_valid = 1'b0;
    logic  o_in_ready;
    t_data i_value = '0;
    logic  i_batch_end = 1'b0;
    logic  o_out_valid;
    logic  i_out_ready = 1'b0;
    t_data o_sorted_value;
    logic  o_final_result;
    logic  o_overflowed;

    t_request pending_requests[$];
    t_result  expected_sorted[$];
    t_data    batch_store[DEPTH];
    int       batch_fill = 0;
    logic     batch_dropped = 1'b0;

    logic in_taken = 1'b0;
    logic quiet = 1'b0;
    int   in_gap = 0;
    int   out_gap = 0;
    int   mismatches = 0;
    int   requests_taken = 0;
    int   results_seen = 0;
    int   batches_sorted = 0;
    int   overflow_batches = 0;

    insertion_sort_engine uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_value        (i_value),
        .i_batch_end    (i_batch_end),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_sorted_value (o_sorted_value),
        .o_final_result (o_final_result),
        .o_overflowed   (o_overflowed)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    task automatic insert_request(input t_data v, input logic last);
        int      pos;
        t_result r;
        if (batch_fill < DEPTH) begin
            pos = batch_fill;
            while (pos > 0 && batch_store[pos-1] > v) begin
                batch_store[pos] = batch_store[pos-1];
                pos--;
            end
            batch_store[pos] = v;
            batch_fill++;
        end else begin
            batch_dropped = 1'b1;
        end
        if (last) begin
            for (int k = 0; k < batch_fill; k++) begin
                r.value = batch_store[k];
                r.last  = (k == batch_fill - 1);
                r.ovf   = batch_dropped;
                expected_sorted.push_back(r);
            end
            batches_sorted++;
            if (batch_dropped)
                overflow_batches++;
            batch_fill    = 0;
            batch_dropped = 1'b0;
        end
    endtask

    task automatic report_mismatch(input string what, input t_result want,
                                   input t_result got);
        mismatches++;
        if (mismatches <= 10)
            $display("mismatch (%s): want %0d/%0b/%0b, got %0d/%0b/%0b",
                     what, want.value, want.last, want.ovf, got.value, got.last, got.ovf);
    endtask

    // check accepted results against the sorted batch
    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        in_taken <= i_rst_n && i_in_valid && o_in_ready;
        if (i_rst_n && i_in_valid && o_in_ready) begin
            requests_taken++;
            insert_request(i_value, i_batch_end);
        end
        if (i_rst_n && o_out_valid && i_out_ready) begin
            results_seen++;
            got.value = o_sorted_value;
            got.last  = o_final_result;
            got.ovf   = o_overflowed;
            if (expected_sorted.size() == 0) begin
                want = '{default: 'x};
                report_mismatch("no result expected", want, got);
            end else begin
                want = expected_sorted.pop_front();
                if (got.value !== want.value || got.last !== want.last || got.ovf !== want.ovf)
                    report_mismatch("field", want, got);
            end
        end
    end

    // request driver
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid  <= 1'b0;
            i_value     <= '0;
            i_batch_end <= 1'b0;
        end else begin
            if (in_taken && pending_requests.size() > 0)
                void'(pending_requests.pop_front());
            quiet <= (pending_requests.size() < 40);
            if (!i_in_valid || in_taken) begin
                if (in_gap > 0) begin
                    in_gap--;
                    i_in_valid <= 1'b0;
                end else if (pending_requests.size() == 0) begin
                    i_in_valid <= 1'b0;
                end else if (pending_requests[0].wait_drain && expected_sorted.size() != 0) begin
                    i_in_valid <= 1'b0;
                end else if (!quiet && $urandom_range(0, 9) == 0) begin
                    in_gap = $urandom_range(1, 19) - 1;
                    i_in_valid <= 1'b0;
                end else begin
                    i_in_valid  <= 1'b1;
                    i_value     <= pending_requests[0].value;
                    i_batch_end <= pending_requests[0].batch_end;
                end
            end
        end
    end

    // result backpressure
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else if (out_gap > 0) begin
            out_gap--;
            i_out_ready <= 1'b0;
        end else if (!quiet && $urandom_range(0, 7) == 0) begin
            out_gap = $urandom_range(1, 19) - 1;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    function automatic void add_request(input t_data v, input logic last, input logic hold);
        t_request q;
        q.value      = v;
        q.batch_end  = last;
        q.wait_drain = hold;
        pending_requests.push_back(q);
    endfunction

    function automatic t_data pick_value();
        int s;
        case ($urandom_range(0, 3))
            0, 1: return t_data'($urandom);
            2: begin
                s = $urandom_range(0, 8);
                return t_data'(s - 4);
            end
            default: begin
                case ($urandom_range(0, 3))
                    0: return VMIN;
                    1: return VMAX;
                    2: return '0;
                    default: return '1;
                endcase
            end
        endcase
    endfunction

    initial begin
        int   queued;
        int   len;
        logic hold;

        add_request(VMIN, 1'b1, 1'b0);

        add_request(VMAX, 1'b0, 1'b0);
        add_request(VMIN, 1'b0, 1'b0);
        add_request('0, 1'b0, 1'b0);
        add_request('1, 1'b0, 1'b0);
        add_request(t_data'(1), 1'b0, 1'b0);
        add_request(VMAX, 1'b0, 1'b0);
        add_request(VMIN, 1'b0, 1'b0);
        add_request('1, 1'b1, 1'b0);

        add_request(t_data'(5), 1'b0, 1'b1);
        add_request(t_data'(-3), 1'b0, 1'b0);
        add_request(t_data'(5), 1'b0, 1'b0);
        add_request(t_data'(5), 1'b0, 1'b0);
        add_request(t_data'(-3), 1'b1, 1'b0);

        // overflow batch: the ending request arrives with the store full
        for (int k = 0; k <= DEPTH; k++)
            add_request(pick_value(), k == DEPTH, 1'b0);

        queued = 0;
        while (queued < RANDOM_ITEMS) begin
            len  = $urandom_range(1, 10);
            hold = ($urandom_range(0, 5) == 0);
            for (int k = 0; k < len; k++)
                add_request(pick_value(), k == len - 1, hold && k == 0);
            queued += len;
        end

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_requests.size() != 0 || i_in_valid)
            @(posedge i_clk);
        while (expected_sorted.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);

        $display("sorted %0d batches from %0d requests, %0d results checked",
                 batches_sorted, requests_taken, results_seen);
        $display("%0d batches overflowed the store", overflow_batches);
        if (mismatches == 0 && expected_sorted.size() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("%0d mismatches, %0d results still expected", mismatches,
                     expected_sorted.size());
            $display("FAILED: results differ");
        end
        $finish;
    end

    initial begin
        #(CLK_PERIOD * 300000);
        $display("timeout waiting for the sorter");
        $display("FAILED: results differ");
        $finish;
    end

endmodule

>>> filelist.f
hdl/isrt_pkg.sv
hdl/isrt_cell.sv
hdl/insertion_sort_engine.sv
hdl/isrt_chk.sv
test/tb.sv
